/* src/clcd_pkg.sv */
`timescale 1ns / 1ps

package clcd_pkg;

  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned COUNT_W   = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_WAIT_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_WAIT_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS         = 3'd4;

  localparam logic [CFG_W-1:0] RST_TICKS_PER_MS     = 8'd10;
  localparam logic [CFG_W-1:0] RST_POWER_ON_WAIT_MS = 8'd15;
  localparam logic [CFG_W-1:0] RST_WAKE_WAIT_MS     = 8'd5;
  localparam logic [CFG_W-1:0] RST_SHORT_WAIT_MS    = 8'd1;
  localparam logic [CFG_W-1:0] RST_PULSE_MS         = 8'd1;

  // sequence steps
  localparam logic [STEP_W-1:0] STEP_POWER_ON_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WAKE_WAIT     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SHORT_WAIT    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_READY         = 4'd11;
  localparam logic [STEP_W-1:0] STEP_WRITE         = 4'd12;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_BUSY     = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] ticks_per_ms;
    logic [CFG_W-1:0] power_on_wait_ms;
    logic [CFG_W-1:0] wake_wait_ms;
    logic [CFG_W-1:0] short_wait_ms;
    logic [CFG_W-1:0] pulse_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] write_status;
    logic       ready_res;
    logic       enable_pin;
    logic       rw_pin;
    logic       rs_pin;
    logic [7:0] bus_data;
  } result_t;

  function automatic logic step_is_cmd(input logic [STEP_W-1:0] s);
    case (s)
      4'd1, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: step_is_cmd = 1'b1;
      default: step_is_cmd = 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] step_byte(input logic [STEP_W-1:0] s);
    case (s)
      4'd1, 4'd3, 4'd5: step_byte = 8'h30;
      4'd6:             step_byte = 8'h38;
      4'd7:             step_byte = 8'h01;
      4'd8:             step_byte = 8'h02;
      4'd9:             step_byte = 8'h0F;
      4'd10:            step_byte = 8'h06;
      default:          step_byte = 8'h00;
    endcase
  endfunction

endpackage

/* src/char_lcd_init_and_write_sequencer.sv */
`timescale 1ns / 1ps
// Path: an input transaction is held in the input register, and its result is captured in the result register.
// Throughput: one transaction per cycle while m_tready does not stall the output; the sequencer state
// updates on the same clock edge that loads the result register.
// Reset: synchronous, active high; the config and control registers take their defaults and the power-on sequence
// restarts at the power-on wait step.

module char_lcd_init_and_write_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [clcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clcd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // data_byte
  input  logic [1:0]                        s_tuser,  // opcode, reg_select
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata   // bus_data, rs_pin, rw_pin, enable_pin,
                                                      // ready_res, write_status, zero pad
);
  import clcd_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic       in_valid;
  logic       in_opcode;
  logic       in_rs;
  logic [7:0] in_byte;
  logic       fire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_ms     <= RST_TICKS_PER_MS;
      cfg.power_on_wait_ms <= RST_POWER_ON_WAIT_MS;
      cfg.wake_wait_ms     <= RST_WAKE_WAIT_MS;
      cfg.short_wait_ms    <= RST_SHORT_WAIT_MS;
      cfg.pulse_ms         <= RST_PULSE_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_MS:     cfg.ticks_per_ms     <= cfg_data;
        CFG_POWER_ON_WAIT_MS: cfg.power_on_wait_ms <= cfg_data;
        CFG_WAKE_WAIT_MS:     cfg.wake_wait_ms     <= cfg_data;
        CFG_SHORT_WAIT_MS:    cfg.short_wait_ms    <= cfg_data;
        CFG_PULSE_MS:         cfg.pulse_ms         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode <= s_tuser[0];
      in_rs     <= s_tuser[1];
      in_byte   <= s_tdata;
    end
  end

  clcd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .opcode     (in_opcode),
    .reg_select (in_rs),
    .data_byte  (in_byte),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, result};
    end
  end

endmodule

/* src/clcd_core.sv */
`timescale 1ns / 1ps

module clcd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             opcode,
  input  logic             reg_select,
  input  logic [7:0]       data_byte,
  input  clcd_pkg::cfg_t   cfg,
  output clcd_pkg::result_t result
);
  import clcd_pkg::*;

  logic [STEP_W-1:0]  step_index, step_index_next;
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic [7:0]         held_data, held_data_next;
  logic               held_rs, held_rs_next;
  logic               enable_level, enable_level_next;
  logic [1:0]         status;

  logic               ready_now;
  logic [CFG_W-1:0]   ms_sel;
  logic [COUNT_W-1:0] dur;
  logic [COUNT_W-1:0] write_dur;
  logic [COUNT_W-1:0] count_inc;

  always_comb begin
    ready_now = (step_index >= STEP_READY) && (step_index != STEP_WRITE);
    case (step_index)
      STEP_POWER_ON_WAIT: ms_sel = cfg.power_on_wait_ms;
      STEP_WAKE_WAIT:     ms_sel = cfg.wake_wait_ms;
      STEP_SHORT_WAIT:    ms_sel = cfg.short_wait_ms;
      default:            ms_sel = cfg.pulse_ms;
    endcase
    dur       = {8'd0, ms_sel} * {8'd0, cfg.ticks_per_ms};
    write_dur = {8'd0, cfg.pulse_ms} * {8'd0, cfg.ticks_per_ms};
    count_inc = tick_count + 16'd1;
  end

  always_comb begin
    step_index_next   = step_index;
    tick_count_next   = tick_count;
    held_data_next    = held_data;
    held_rs_next      = held_rs;
    enable_level_next = enable_level;
    status            = STATUS_NONE;
    if (opcode == OP_WRITE) begin
      if (ready_now) begin
        held_data_next = data_byte;
        held_rs_next   = reg_select;
        status         = STATUS_ACCEPTED;
        if (write_dur == '0) begin
          enable_level_next = 1'b0;
          tick_count_next   = '0;
          step_index_next   = STEP_READY;
        end else begin
          enable_level_next = 1'b1;
          tick_count_next   = 16'd1;
          step_index_next   = STEP_WRITE;
        end
      end else begin
        status = STATUS_BUSY;
      end
    end else if (!ready_now) begin
      if (tick_count == '0 && step_index < STEP_READY && step_is_cmd(step_index)) begin
        held_data_next    = step_byte(step_index);
        held_rs_next      = 1'b0;
        enable_level_next = 1'b1;
      end
      tick_count_next = count_inc;
      if (count_inc > dur) begin
        enable_level_next = 1'b0;
        tick_count_next   = '0;
        step_index_next   = (step_index == STEP_WRITE) ? STEP_READY : step_index + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index   <= STEP_POWER_ON_WAIT;
      tick_count   <= '0;
      held_data    <= '0;
      held_rs      <= 1'b0;
      enable_level <= 1'b0;
    end else if (fire) begin
      step_index   <= step_index_next;
      tick_count   <= tick_count_next;
      held_data    <= held_data_next;
      held_rs      <= held_rs_next;
      enable_level <= enable_level_next;
    end
  end

  always_comb begin
    result.bus_data     = held_data_next;
    result.rs_pin       = held_rs_next;
    result.rw_pin       = 1'b0;
    result.enable_pin   = enable_level_next;
    result.ready_res    = (step_index_next >= STEP_READY) && (step_index_next != STEP_WRITE);
    result.write_status = status;
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import clcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned LONG_HOLD = 300;

  // predicts the LCD pin levels per transaction and checks them in order
  class lcd_pin_scoreboard;
    cfg_t        regs;
    logic [3:0]  step;
    logic [15:0] tick_count;
    logic [7:0]  held_data;
    logic        held_rs;
    logic        enable_level;
    result_t     pin_levels_q[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_accepted;
    int unsigned n_busy;

    function new();
      regs.ticks_per_ms     = RST_TICKS_PER_MS;
      regs.power_on_wait_ms = RST_POWER_ON_WAIT_MS;
      regs.wake_wait_ms     = RST_WAKE_WAIT_MS;
      regs.short_wait_ms    = RST_SHORT_WAIT_MS;
      regs.pulse_ms         = RST_PULSE_MS;
      step         = STEP_POWER_ON_WAIT;
      tick_count   = '0;
      held_data    = '0;
      held_rs      = 1'b0;
      enable_level = 1'b0;
      n_errors     = 0;
      n_checked    = 0;
      n_accepted   = 0;
      n_busy       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TICKS_PER_MS:     regs.ticks_per_ms = val;
        CFG_POWER_ON_WAIT_MS: regs.power_on_wait_ms = val;
        CFG_WAKE_WAIT_MS:     regs.wake_wait_ms = val;
        CFG_SHORT_WAIT_MS:    regs.short_wait_ms = val;
        CFG_PULSE_MS:         regs.pulse_ms = val;
        default: ;
      endcase
    endfunction

    function bit is_ready();
      return (step >= STEP_READY) && (step != STEP_WRITE);
    endfunction

    function int pending();
      return pin_levels_q.size();
    endfunction

    function logic [7:0] duration_ms(logic [3:0] s);
      case (s)
        STEP_POWER_ON_WAIT: return regs.power_on_wait_ms;
        STEP_WAKE_WAIT:     return regs.wake_wait_ms;
        STEP_SHORT_WAIT:    return regs.short_wait_ms;
        default:            return regs.pulse_ms;
      endcase
    endfunction

    // {is command, command byte} of an init step
    function logic [8:0] init_command(logic [3:0] s);
      case (s)
        4'd1, 4'd3, 4'd5: return 9'h130;
        4'd6:             return 9'h138;
        4'd7:             return 9'h101;
        4'd8:             return 9'h102;
        4'd9:             return 9'h10F;
        4'd10:            return 9'h106;
        default:          return 9'h000;
      endcase
    endfunction

    function void note_input(logic op, logic rs, logic [7:0] data_byte);
      int unsigned dur;
      logic [1:0]  status;
      logic [8:0]  cmd;
      bit          was_ready;
      result_t     r;
      was_ready = is_ready();
      status = STATUS_NONE;
      if (op == OP_WRITE) begin
        if (was_ready) begin
          dur = 32'(regs.pulse_ms) * 32'(regs.ticks_per_ms);
          held_data = data_byte;
          held_rs = rs;
          enable_level = 1'b1;
          tick_count = 16'd1;
          step = STEP_WRITE;
          status = STATUS_ACCEPTED;
          n_accepted++;
          if (dur < 1) begin
            enable_level = 1'b0;
            tick_count = '0;
            step = STEP_READY;
          end
        end else begin
          status = STATUS_BUSY;
          n_busy++;
        end
      end else if (!was_ready) begin
        dur = 32'(duration_ms(step)) * 32'(regs.ticks_per_ms);
        cmd = init_command(step);
        if (tick_count == 0 && step < STEP_READY && cmd[8]) begin
          held_data = cmd[7:0];
          held_rs = 1'b0;
          enable_level = 1'b1;
        end
        tick_count = tick_count + 16'd1;
        if (32'(tick_count) > dur) begin
          enable_level = 1'b0;
          tick_count = '0;
          step = (step == STEP_WRITE) ? STEP_READY : step + 4'd1;
        end
      end
      r.bus_data     = held_data;
      r.rs_pin       = held_rs;
      r.rw_pin       = 1'b0;
      r.enable_pin   = enable_level;
      r.ready_res    = is_ready();
      r.write_status = status;
      pin_levels_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [15:0] data);
      result_t got;
      result_t want;
      got = data[13:0];
      if (pin_levels_q.size() == 0) begin
        $error("unexpected result transaction 0x%h", data);
        n_errors++;
        return;
      end
      want = pin_levels_q.pop_front();
      n_checked++;
      compare_field("bus_data", 32'(want.bus_data), 32'(got.bus_data));
      compare_field("rs_pin", 32'(want.rs_pin), 32'(got.rs_pin));
      compare_field("rw_pin", 32'(want.rw_pin), 32'(got.rw_pin));
      compare_field("enable_pin", 32'(want.enable_pin), 32'(got.enable_pin));
      compare_field("ready_res", 32'(want.ready_res), 32'(got.ready_res));
      compare_field("write_status", 32'(want.write_status), 32'(got.write_status));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;

  lcd_pin_scoreboard sb;
  bit          hold_off_req;
  int unsigned burst_left;
  int unsigned n_sent;
  int unsigned n_phases;
  int unsigned cycles;

  char_lcd_init_and_write_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL char_lcd_init_and_write_sequencer");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
    end
  end

  // sink: chunks of always-ready, random, fixed pattern and sparse ready, with a long ready-low hold on request
  initial begin : sink
    int unsigned mode;
    int unsigned left;
    int unsigned pat;
    pat = 0;
    forever begin
      if (hold_off_req) begin
        repeat (LONG_HOLD) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
        hold_off_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 80);
      repeat (left) begin
        pat++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (pat % 5) != 0;
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_item(logic op, logic rs, logic [7:0] data_byte);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data_byte;
    s_tuser  <= {rs, op};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, rs, data_byte);
    n_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes mostly while ready, occasional rejected writes while busy
  task automatic send_random();
    logic op;
    op = ($urandom_range(0, 99) < (sb.is_ready() ? 60 : 8)) ? OP_WRITE : OP_TICK;
    send_item(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(logic [CFG_W-1:0] tpm, logic [CFG_W-1:0] pulse,
                           int unsigned n, bit long_hold);
    wait_drained();
    write_reg(CFG_TICKS_PER_MS, tpm);
    write_reg(CFG_PULSE_MS, pulse);
    n_phases++;
    if (long_hold) hold_off_req = 1'b1;
    repeat (n) send_random();
  endtask

  initial begin : main
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    sb = new();
    hold_off_req = 1'b0;
    burst_left = 0;
    n_sent = 0;
    n_phases = 1;
    cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-length power-on and short waits, longest wake wait
    write_reg(CFG_TICKS_PER_MS, 8'd1);
    write_reg(CFG_POWER_ON_WAIT_MS, 8'd0);
    write_reg(CFG_WAKE_WAIT_MS, 8'd255);
    write_reg(CFG_SHORT_WAIT_MS, 8'd0);
    write_reg(CFG_PULSE_MS, 8'd1);

    while (!sb.is_ready()) begin
      send_item(($urandom_range(0, 9) == 0) ? OP_WRITE : OP_TICK,
                1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end

    send_item(OP_TICK, 1'b1, 8'hFF);
    send_item(OP_WRITE, 1'b0, 8'h00);
    send_item(OP_WRITE, 1'b1, 8'hFF);
    send_item(OP_TICK, 1'b0, 8'h00);
    send_item(OP_WRITE, 1'b1, 8'hFF);
    send_item(OP_TICK, 1'b1, 8'hFF);
    send_item(OP_WRITE, 1'b0, 8'hA5);
    send_item(OP_TICK, 1'b0, 8'h00);
    send_item(OP_WRITE, 1'b1, 8'h5A);
    send_item(OP_TICK, 1'b0, 8'h00);
    send_item(OP_TICK, 1'b0, 8'h00);

    // zero-length enable pulse: E never shows high
    wait_drained();
    write_reg(CFG_PULSE_MS, 8'd0);
    n_phases++;
    send_item(OP_WRITE, 1'b1, 8'h3C);
    send_item(OP_WRITE, 1'b0, 8'hC3);
    send_item(OP_TICK, 1'b1, 8'h81);
    send_item(OP_WRITE, 1'b1, 8'h7E);

    run_phase(8'd1, 8'd1, 100, 1'b1);
    run_phase(8'd255, 8'd1, 150, 1'b0);
    run_phase(8'd1, 8'd255, 150, 1'b0);
    repeat (3) begin
      run_phase(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 80, 1'b0);
    end
    wait_drained();

    $display("%0d transactions over %0d settings, %0d results checked",
             n_sent, n_phases, sb.n_checked);
    $display("init sequence plus %0d accepted and %0d busy-rejected writes",
             sb.n_accepted, sb.n_busy);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS char_lcd_init_and_write_sequencer");
    end else begin
      $display("FAIL char_lcd_init_and_write_sequencer");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/clcd_pkg.sv
src/clcd_core.sv
src/char_lcd_init_and_write_sequencer.sv
verif/tb_top.sv
